// ===== hdl/orle_pkg.sv =====
// Shared types and constants for the ordered record list engine.
`default_nettype none
package orle_pkg;

   localparam int CMD_W = 3;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 3'd0,
      CMD_READ   = 3'd1,
      CMD_DELETE = 3'd2,
      CMD_PRED   = 3'd3,
      CMD_SUCC   = 3'd4,
      CMD_CLEAR  = 3'd5,
      CMD_RSVD6  = 3'd6,
      CMD_RSVD7  = 3'd7
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_RANGE    = 2'd1,
      ST_NOTFOUND = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   // controller -> datapath commands
   typedef struct packed {
      logic load;      // capture request transaction
      logic rd_en;     // read memory at rd_addr
      logic wr_en;     // write memory at wr_addr
      logic wr_new;    // write data is the new record, else the read-data register
      logic emit;      // latch response
      logic emit_rec;  // response carries the record read last cycle
      logic len_inc;
      logic len_dec;
      logic len_clr;
   } ctl_cmd_type;

   // record read-data layout: name in top 64 bits, info in low 40
   localparam int NAME_W = 64;
   localparam int INFO_W = 40;
   localparam int REC_W  = NAME_W + INFO_W;

   // keep bytes up to the first zero byte, within nbytes
   function automatic logic [NAME_W-1:0] norm_name(input logic [NAME_W-1:0] v,
                                                   input int nbytes);
      logic [NAME_W-1:0] r;
      logic              stop;
      r    = '0;
      stop = 1'b0;
      for (int b = 0; b < 8; b++) begin
         if (b >= nbytes || v[8*b +: 8] == 8'd0) stop = 1'b1;
         if (!stop) r[8*b +: 8] = v[8*b +: 8];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== hdl/orle_datapath.sv =====
// Datapath: record memory, length register, request registers and response register.
`default_nettype none
module orle_datapath #(
   parameter int CAPACITY   = 128,
   parameter int NAME_BYTES = 8,
   parameter int AW         = 7,
   parameter int LW         = 8
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire  orle_pkg::ctl_cmd_type cmd,
   input  wire  [AW-1:0]              rd_addr,
   input  wire  [AW-1:0]              wr_addr,
   input  wire  [AW-1:0]              emit_idx,
   input  wire  [1:0]                 emit_status,
   input  wire  [2:0]                 req_cmd,
   input  wire  [7:0]                 req_pos,
   input  wire  [63:0]                req_name,
   input  wire  [39:0]                req_info,
   output logic [LW-1:0]              len,
   output logic                       name_match,
   output logic [2:0]                 cur_cmd,
   output logic [7:0]                 cur_pos,
   output logic [143:0]               rsp_word
);
   import orle_pkg::*;

   logic [REC_W-1:0]  mem [CAPACITY];
   logic [REC_W-1:0]  rdata_ff;
   logic [NAME_W-1:0] key_ff, key_in;
   logic [INFO_W-1:0] info_ff;
   logic [2:0]        cmd_ff;
   logic [7:0]        pos_ff;
   logic [LW-1:0]     len_ff, len_in;
   logic [143:0]      rsp_ff, rsp_in;
   logic [9:0]        tot;
   logic [7:0]        mean;
   logic [7:0]        cnt8;

   assign key_in = norm_name(req_name, NAME_BYTES);

   always_ff @(posedge clock) begin
      if (cmd.rd_en) rdata_ff <= mem[rd_addr];
      if (cmd.wr_en) mem[wr_addr] <= cmd.wr_new ? {key_ff, info_ff} : rdata_ff;
      if (cmd.load) begin
         key_ff  <= key_in;
         info_ff <= req_info;
         cmd_ff  <= req_cmd;
         pos_ff  <= req_pos;
      end
   end

   always_comb begin
      len_in = len_ff;
      if (cmd.len_clr)      len_in = '0;
      else if (cmd.len_inc) len_in = len_ff + 1'b1;
      else if (cmd.len_dec) len_in = len_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) len_ff <= '0;
      else       len_ff <= len_in;
   end

   assign tot  = 10'(rdata_ff[23:16]) + 10'(rdata_ff[15:8]) + 10'(rdata_ff[7:0]);
   assign mean = 8'((20'(tot) * 20'd683) >> 11);   // exact /3 for tot <= 765
   assign cnt8 = 8'(len_in);

   // rsp word: status, pos, id, name, a, b, c, total, mean, count, empty
   always_comb begin
      rsp_in = '0;
      rsp_in[1:0]     = emit_status;
      if (cmd.emit_rec) begin
         rsp_in[9:2]     = 8'(emit_idx) + 8'd1;
         rsp_in[25:10]   = rdata_ff[39:24];
         rsp_in[89:26]   = rdata_ff[REC_W-1 -: NAME_W];
         rsp_in[97:90]   = rdata_ff[23:16];
         rsp_in[105:98]  = rdata_ff[15:8];
         rsp_in[113:106] = rdata_ff[7:0];
         rsp_in[123:114] = tot;
         rsp_in[131:124] = mean;
      end
      rsp_in[139:132] = cnt8;
      rsp_in[140]     = (len_in == '0);
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) rsp_ff <= rsp_in;
   end

   assign len        = len_ff;
   assign name_match = (rdata_ff[REC_W-1 -: NAME_W] == key_ff);
   assign cur_cmd    = cmd_ff;
   assign cur_pos    = pos_ff;
   assign rsp_word   = rsp_ff;
endmodule
`default_nettype wire

// ===== hdl/orle_ctrl.sv =====
// Controller: sequences each command over the record memory.
`default_nettype none
module orle_ctrl #(
   parameter int CAPACITY = 128,
   parameter int AW       = 7,
   parameter int LW       = 8
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_fire,
   input  wire                         rsp_taken,
   input  wire  [LW-1:0]               len,
   input  wire                         name_match,
   input  wire  [2:0]                  cur_cmd,
   input  wire  [7:0]                  cur_pos,
   output orle_pkg::ctl_cmd_type        cmd,
   output logic [AW-1:0]               rd_addr,
   output logic [AW-1:0]               wr_addr,
   output logic [AW-1:0]               emit_idx,
   output logic [1:0]                  emit_status,
   output logic                        idle,
   output logic                        rsp_valid
);
   import orle_pkg::*;

   localparam int PW = (LW > 8) ? LW : 8;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_DEC   = 7'b0000010,
      S_SHUP  = 7'b0000100,
      S_SHDN  = 7'b0001000,
      S_SRCH  = 7'b0010000,
      S_EMIT  = 7'b0100000,
      S_HOLD  = 7'b1000000
   } state_type;

   state_type     state_ff, state_in;
   logic [LW-1:0] j_ff, j_in;        // walking index
   logic [LW-1:0] p_ff, p_in;        // target index (pos-1)
   logic [1:0]    st_ff, st_in;
   logic          rec_ff, rec_in;
   logic          rdv_ff, rdv_in;    // read issued last cycle, rdata valid
   logic          vld_ff, vld_in;
   logic [PW-1:0] pos_w;
   logic [LW-1:0] last_ff, last_in;  // index whose read data is in rdata

   assign pos_w = PW'(cur_pos);

   always_comb begin
      state_in = state_ff;
      j_in = j_ff; p_in = p_ff; st_in = st_ff; rec_in = rec_ff;
      rdv_in = 1'b0; vld_in = vld_ff; last_in = last_ff;
      cmd = '0;
      rd_addr = AW'(j_ff); wr_addr = AW'(j_ff);
      if (rsp_taken) vld_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            cmd.load = req_fire;
            if (req_fire) state_in = S_DEC;
         end
         S_DEC: begin
            st_in = ST_OK; rec_in = 1'b0;
            p_in = LW'(pos_w - 1'b1);
            unique case (cmd_type'(cur_cmd))
               CMD_INSERT: begin
                  if (pos_w == '0 || pos_w > PW'(len) + 1'b1) begin
                     st_in = ST_RANGE; state_in = S_EMIT;
                  end else if (len >= LW'(CAPACITY)) begin
                     st_in = ST_FULL; state_in = S_EMIT;
                  end else begin
                     j_in = len; state_in = S_SHUP;
                  end
               end
               CMD_READ, CMD_DELETE: begin
                  if (pos_w == '0 || pos_w > PW'(len)) begin
                     st_in = ST_RANGE; state_in = S_EMIT;
                  end else begin
                     cmd.rd_en = 1'b1; rd_addr = AW'(pos_w - 1'b1);
                     last_in = LW'(pos_w - 1'b1); rec_in = 1'b1;
                     j_in = LW'(pos_w);
                     state_in = (cmd_type'(cur_cmd) == CMD_READ) ? S_EMIT : S_SHDN;
                  end
               end
               CMD_PRED, CMD_SUCC: begin
                  st_in = ST_NOTFOUND;
                  j_in = (cmd_type'(cur_cmd) == CMD_PRED) ? LW'(1) : '0;
                  state_in = S_SRCH;
               end
               CMD_CLEAR: begin
                  cmd.len_clr = 1'b1; state_in = S_EMIT;
               end
               default: state_in = S_EMIT;
            endcase
         end
         S_SHUP: begin
            // read j-1 then write j; reads and writes alternate using rdv
            if (j_ff == p_ff) begin
               if (!rdv_ff) begin
                  cmd.wr_en = 1'b1; cmd.wr_new = 1'b1; wr_addr = AW'(p_ff);
                  rdv_in = 1'b1;
               end else begin
                  cmd.rd_en = 1'b1; rd_addr = AW'(p_ff); last_in = p_ff;
                  cmd.len_inc = 1'b1; rec_in = 1'b1; state_in = S_EMIT;
               end
            end else if (!rdv_ff) begin
               cmd.rd_en = 1'b1; rd_addr = AW'(j_ff - 1'b1); rdv_in = 1'b1;
            end else begin
               cmd.wr_en = 1'b1; wr_addr = AW'(j_ff); j_in = j_ff - 1'b1;
            end
         end
         S_SHDN: begin
            // first cycle: rdata holds the removed record, send it, then shift down
            if (rec_ff) begin
               cmd.len_dec = 1'b1; cmd.emit = 1'b1; cmd.emit_rec = 1'b1;
               vld_in = 1'b1; rec_in = 1'b0;
            end else if (j_ff == len + 1'b1) begin
               state_in = S_HOLD;
            end else if (!rdv_ff) begin
               cmd.rd_en = 1'b1; rd_addr = AW'(j_ff); rdv_in = 1'b1;
            end else begin
               cmd.wr_en = 1'b1; wr_addr = AW'(j_ff - 1'b1); j_in = j_ff + 1'b1;
            end
         end
         S_SRCH: begin
            if (!rdv_ff) begin
               if (LW'(j_ff + 1'b1) > len || (cmd_type'(cur_cmd) == CMD_SUCC
                   && LW'(j_ff + 1'b1) >= len)) begin
                  state_in = S_EMIT;
               end else begin
                  cmd.rd_en = 1'b1; rd_addr = AW'(j_ff); rdv_in = 1'b1;
               end
            end else if (name_match) begin
               last_in = (cmd_type'(cur_cmd) == CMD_PRED) ? j_ff - 1'b1 : j_ff + 1'b1;
               cmd.rd_en = 1'b1; rd_addr = AW'(last_in);
               st_in = ST_OK; rec_in = 1'b1; state_in = S_EMIT;
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         S_EMIT: begin
            if (!vld_ff) begin
               cmd.emit = 1'b1; cmd.emit_rec = rec_ff;
               vld_in = 1'b1; state_in = S_HOLD;
            end
         end
         S_HOLD: begin
            if (!vld_ff || rsp_taken) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         vld_ff   <= 1'b0;
         rdv_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         vld_ff   <= vld_in;
         rdv_ff   <= rdv_in;
      end
      j_ff <= j_in; p_ff <= p_in; st_ff <= st_in; rec_ff <= rec_in; last_ff <= last_in;
   end

   assign emit_idx    = AW'(last_ff);
   assign emit_status = st_ff;
   assign idle        = (state_ff == S_IDLE);
   assign rsp_valid   = vld_ff;
endmodule
`default_nettype wire

// ===== hdl/ordered_record_list_engine.sv =====
// Top level of the ordered record list engine: controller plus datapath.
// One transaction at a time: the next request is accepted only after the response is
// taken and, for a delete, after the records behind it have been shifted down.
// Reset (synchronous, active high) empties the list; memory contents are not cleared.
`default_nettype none
module ordered_record_list_engine #(
   parameter int CAPACITY   = 128,
   parameter int NAME_BYTES = 8
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   // command[2:0], position[10:3], key_name[74:11], student_id[90:75],
   // score_a[98:91], score_b[106:99], score_c[114:107], zero fill
   input  wire  [119:0] req_tdata,
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   // status[1:0], found_position[9:2], out_id[25:10], out_name[89:26],
   // out_score_a[97:90], out_score_b[105:98], out_score_c[113:106],
   // total[123:114], mean[131:124], entry_count[139:132], is_empty[140], zero fill
   output logic [143:0] rsp_tdata
);
   import orle_pkg::*;

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   // room for count + 1 so range checks never wrap
   localparam int LW = $clog2(CAPACITY + 2);

   ctl_cmd_type   cmd;
   logic [AW-1:0] rd_addr, wr_addr, emit_idx;
   logic [1:0]    emit_status;
   logic [LW-1:0] len;
   logic          name_match, idle;
   logic [2:0]    cur_cmd;
   logic [7:0]    cur_pos;
   logic [143:0]  rsp_word;

   // accept only while idle; idle returns once the previous result is taken
   assign req_tready = idle;

   orle_ctrl #(.CAPACITY(CAPACITY), .AW(AW), .LW(LW)) u_ctrl (
      .clock, .reset,
      .req_fire   (req_tvalid & req_tready),
      .rsp_taken  (rsp_tvalid & rsp_tready),
      .len, .name_match, .cur_cmd, .cur_pos,
      .cmd, .rd_addr, .wr_addr, .emit_idx, .emit_status,
      .idle, .rsp_valid(rsp_tvalid)
   );

   orle_datapath #(.CAPACITY(CAPACITY), .NAME_BYTES(NAME_BYTES), .AW(AW), .LW(LW))
   u_dp (
      .clock, .reset, .cmd, .rd_addr, .wr_addr, .emit_idx, .emit_status,
      .req_cmd  (req_tdata[2:0]),
      .req_pos  (req_tdata[10:3]),
      .req_name (req_tdata[74:11]),
      .req_info ({req_tdata[90:75], req_tdata[98:91], req_tdata[106:99],
                  req_tdata[114:107]}),
      .len, .name_match, .cur_cmd, .cur_pos, .rsp_word
   );

   assign rsp_tdata = rsp_word;
endmodule
`default_nettype wire

// ===== hdl/orle_checker.sv =====
// Port-level checker for the ordered record list engine, bound to the top level.
`default_nettype none
module orle_checker (
   input wire         clock,
   input wire         reset,
   input wire         req_tvalid,
   input wire         req_tready,
   input wire         rsp_tvalid,
   input wire         rsp_tready,
   input wire [143:0] rsp_tdata
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response dropped while stalled");
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[140] == (rsp_tdata[139:132] == 8'd0))
      else $error("empty flag disagrees with count");
   a_noreq: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request taken while busy");
   a_mean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] != 2'd0 |-> rsp_tdata[131:2] == '0)
      else $error("error response carries record data");
endmodule

bind ordered_record_list_engine orle_checker u_orle_checker (
   .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready, .rsp_tdata
);
`default_nettype wire

// ===== bench/tb_ordered_record_list_engine.sv =====
// Testbench for the ordered record list engine: directed and random command streams checked against a predictor.
`timescale 1ns / 1ps
module tb_ordered_record_list_engine;
   import orle_pkg::*;

   localparam int CAP       = 128;
   localparam int NBYTES    = 8;
   localparam int WATCH_MAX = 20000;

   // one request transaction, unpacked
   typedef struct {
      cmd_type     cmd;
      logic [7:0]  pos;
      logic [63:0] key;
      logic [15:0] id;
      logic [7:0]  sa, sb, sc;
   } list_cmd_type;

   // one response transaction, unpacked
   typedef struct {
      status_type  status;
      logic [7:0]  fpos;
      logic [15:0] id;
      logic [63:0] name;
      logic [7:0]  sa, sb, sc;
      logic [9:0]  total;
      logic [7:0]  mean;
      logic [7:0]  count;
      logic        empty;
   } list_rsp_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [119:0]  req_tdata = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [143:0]  rsp_tdata;

   ordered_record_list_engine #(.CAPACITY(CAP), .NAME_BYTES(NBYTES)) u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always #10 clock = ~clock;

   // predictor state: shadow copy of the list
   logic [63:0] shadow_name [CAP];
   logic [39:0] shadow_info [CAP];
   int          shadow_len;

   list_cmd_type pending_cmds[$];
   list_rsp_type expected_rsps[$];
   int           fail_count = 0;
   bit           stim_done  = 1'b0;
   int           idle_cycles = 0;
   int           rsp_seen = 0;
   bit           req_taken = 1'b0;

   // keep bytes up to the first zero byte, within NBYTES
   function automatic logic [63:0] trim_name(logic [63:0] v);
      logic [63:0] r;
      r = '0;
      for (int b = 0; b < NBYTES; b++) begin
         if (v[8*b +: 8] == 8'd0) break;
         r[8*b +: 8] = v[8*b +: 8];
      end
      return r;
   endfunction

   function automatic void fill_record(inout list_rsp_type r, input int idx);
      logic [39:0] inf;
      logic [9:0]  t;
      inf    = shadow_info[idx];
      r.fpos = 8'(idx + 1);
      r.id   = inf[39:24];
      r.name = shadow_name[idx];
      r.sa   = inf[23:16];
      r.sb   = inf[15:8];
      r.sc   = inf[7:0];
      t      = 10'(inf[23:16]) + 10'(inf[15:8]) + 10'(inf[7:0]);
      r.total = t;
      r.mean  = 8'(t / 3);
   endfunction

   // apply one command to the shadow list and return the expected response
   function automatic list_rsp_type apply_list_cmd(list_cmd_type c);
      list_rsp_type r;
      int           p;
      logic [63:0]  k;
      r = '{status: ST_OK, default: '0};
      p = c.pos;
      k = trim_name(c.key);
      case (c.cmd)
         CMD_INSERT: begin
            if (p < 1 || p > shadow_len + 1) r.status = ST_RANGE;
            else if (shadow_len >= CAP) r.status = ST_FULL;
            else begin
               for (int j = shadow_len; j >= p; j--) begin
                  shadow_name[j] = shadow_name[j-1];
                  shadow_info[j] = shadow_info[j-1];
               end
               shadow_name[p-1] = k;
               shadow_info[p-1] = {c.id, c.sa, c.sb, c.sc};
               shadow_len++;
               fill_record(r, p - 1);
            end
         end
         CMD_READ: begin
            if (p < 1 || p > shadow_len) r.status = ST_RANGE;
            else fill_record(r, p - 1);
         end
         CMD_DELETE: begin
            if (p < 1 || p > shadow_len) r.status = ST_RANGE;
            else begin
               fill_record(r, p - 1);
               for (int j = p; j < shadow_len; j++) begin
                  shadow_name[j-1] = shadow_name[j];
                  shadow_info[j-1] = shadow_info[j];
               end
               shadow_len--;
            end
         end
         CMD_PRED: begin
            r.status = ST_NOTFOUND;
            // a match at the head has no predecessor, keep looking
            for (int j = 1; j < shadow_len; j++)
               if (shadow_name[j] == k) begin
                  fill_record(r, j - 1);
                  r.status = ST_OK;
                  break;
               end
         end
         CMD_SUCC: begin
            r.status = ST_NOTFOUND;
            // a match at the tail has no successor, keep looking
            for (int j = 0; j + 1 < shadow_len; j++)
               if (shadow_name[j] == k) begin
                  fill_record(r, j + 1);
                  r.status = ST_OK;
                  break;
               end
         end
         CMD_CLEAR: shadow_len = 0;
         default: ;
      endcase
      r.count = 8'(shadow_len);
      r.empty = (shadow_len == 0);
      return r;
   endfunction

   // small pool of names so finds hit often; some carry junk after a zero byte
   function automatic logic [63:0] pick_name();
      logic [63:0] v;
      int          n;
      n = $urandom_range(0, 9);
      v = {$urandom, $urandom};
      if ($urandom_range(0, 4) != 0) begin
         v = 64'h0;
         for (int b = 0; b < 3; b++) v[8*b +: 8] = 8'h41 + 8'((n + b) % 4);
         if ($urandom_range(0, 2) == 0) v[63:32] = $urandom; // hidden tail
         if (n == 0) v[7:0] = 8'h00;                          // empty name
      end
      return v;
   endfunction

   function automatic list_cmd_type make_cmd(cmd_type op, int pos);
      list_cmd_type c;
      c.cmd = op;
      c.pos = 8'(pos);
      c.key = pick_name();
      c.id  = 16'($urandom);
      c.sa  = 8'($urandom);
      c.sb  = 8'($urandom);
      c.sc  = 8'($urandom);
      return c;
   endfunction

   // random gap: mostly zero or short, sometimes long
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // stimulus: directed items then random items; tracks a rough list length
   initial begin
      list_cmd_type c;
      int           est_len;
      int           r;
      cmd_type      op;
      // directed part
      c = make_cmd(CMD_READ, 1);   pending_cmds.push_back(c); // empty read
      c = make_cmd(CMD_PRED, 1);   pending_cmds.push_back(c);
      c = make_cmd(CMD_INSERT, 0); pending_cmds.push_back(c); // position zero
      c = make_cmd(CMD_INSERT, 2); pending_cmds.push_back(c); // beyond end
      c = make_cmd(CMD_INSERT, 1);
      c.key = 64'hFFFF_FFFF_FFFF_FFFF; c.id = 16'hFFFF;
      c.sa = 8'hFF; c.sb = 8'hFF; c.sc = 8'hFF;
      pending_cmds.push_back(c);
      c = make_cmd(CMD_INSERT, 2);
      c.key = 64'h0; c.id = 16'h0; c.sa = 0; c.sb = 0; c.sc = 0;
      pending_cmds.push_back(c);
      c = make_cmd(CMD_INSERT, 1); c.key = 64'hDEAD_0000_0042_4241; pending_cmds.push_back(c);
      c = make_cmd(CMD_PRED, 0); c.key = 64'h0042_4241; pending_cmds.push_back(c);
      c = make_cmd(CMD_SUCC, 0); c.key = 64'h0042_4241; pending_cmds.push_back(c);
      c = make_cmd(CMD_SUCC, 0); c.key = 64'h0; pending_cmds.push_back(c);
      c = make_cmd(CMD_PRED, 0); c.key = 64'h0; pending_cmds.push_back(c);
      c = make_cmd(CMD_READ, 3);   pending_cmds.push_back(c);
      c = make_cmd(CMD_READ, 4);   pending_cmds.push_back(c);
      c = make_cmd(CMD_READ, 255); pending_cmds.push_back(c);
      c = make_cmd(CMD_DELETE, 0); pending_cmds.push_back(c);
      c = make_cmd(CMD_DELETE, 2); pending_cmds.push_back(c);
      c = make_cmd(CMD_RSVD6, 1);  pending_cmds.push_back(c);
      c = make_cmd(CMD_RSVD7, 1);  pending_cmds.push_back(c);
      c = make_cmd(CMD_CLEAR, 0);  pending_cmds.push_back(c);
      c = make_cmd(CMD_DELETE, 1); pending_cmds.push_back(c);
      // fill to capacity, then overflow and both range checks on a full list
      for (int i = 0; i < CAP; i++) begin
         c = make_cmd(CMD_INSERT, $urandom_range(1, i + 1));
         pending_cmds.push_back(c);
      end
      c = make_cmd(CMD_INSERT, CAP + 1); pending_cmds.push_back(c); // full
      c = make_cmd(CMD_INSERT, CAP + 2); pending_cmds.push_back(c); // range wins
      c = make_cmd(CMD_READ, CAP);       pending_cmds.push_back(c);
      c = make_cmd(CMD_DELETE, CAP);     pending_cmds.push_back(c);
      c = make_cmd(CMD_DELETE, 1);       pending_cmds.push_back(c);
      est_len = CAP - 2;
      // random part; mostly in-range positions, inserts weighted to grow the list
      for (int i = 0; i < 1300; i++) begin
         r = $urandom_range(0, 99);
         if (r < 40) op = CMD_INSERT;
         else if (r < 55) op = CMD_READ;
         else if (r < 72) op = CMD_DELETE;
         else if (r < 83) op = CMD_PRED;
         else if (r < 94) op = CMD_SUCC;
         else if (r < 97) op = CMD_CLEAR;
         else op = ($urandom_range(0, 1) != 0) ? CMD_RSVD6 : CMD_RSVD7;
         if ($urandom_range(0, 9) == 0)
            c = make_cmd(op, $urandom_range(0, 255));
         else if (op == CMD_INSERT)
            c = make_cmd(op, $urandom_range(1, est_len + 1));
         else
            c = make_cmd(op, $urandom_range(1, (est_len > 0) ? est_len : 1));
         // keep lists short most of the time to bound the walk latency
         if (est_len > 40 && op == CMD_INSERT && $urandom_range(0, 1) != 0)
            c.cmd = CMD_DELETE;
         if (c.cmd == CMD_INSERT && c.pos >= 1 && c.pos <= est_len + 1 && est_len < CAP)
            est_len++;
         else if (c.cmd == CMD_DELETE && c.pos >= 1 && c.pos <= est_len)
            est_len--;
         else if (c.cmd == CMD_CLEAR)
            est_len = 0;
         pending_cmds.push_back(c);
      end
   end

   // request handshake seen at the rising edge
   always @(posedge clock) begin
      req_taken <= !reset && req_tvalid && req_tready;
   end

   // driver: changes inputs on the falling edge, one transaction per handshake
   int send_gap = 0;
   list_cmd_type drv_cmd;
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_taken) begin
         // hold the offered transaction
      end else begin
         if (req_tvalid) begin
            // previous transaction was accepted at the last rising edge
            expected_rsps.push_back(apply_list_cmd(drv_cmd));
         end
         if (send_gap > 0 || pending_cmds.size() == 0) begin
            if (send_gap > 0) send_gap <= send_gap - 1;
            req_tvalid <= 1'b0;
            if (pending_cmds.size() == 0 && send_gap == 0) stim_done <= 1'b1;
         end else begin
            drv_cmd     = pending_cmds.pop_front();
            req_tdata   <= {5'b0, drv_cmd.sc, drv_cmd.sb, drv_cmd.sa, drv_cmd.id,
                            drv_cmd.key, drv_cmd.pos, drv_cmd.cmd};
            req_tvalid  <= 1'b1;
            send_gap    <= gap_len();
         end
      end
   end

   // receiver backpressure; one long hold-off early on to stall the input
   int hold_cnt = 0;
   int stall_cnt = 0;
   bit long_hold_done = 1'b0;
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (!long_hold_done && rsp_seen == 5) begin
         if (hold_cnt < 400) begin
            hold_cnt   <= hold_cnt + 1;
            rsp_tready <= 1'b0;
         end else begin
            long_hold_done <= 1'b1;
            rsp_tready     <= 1'b1;
         end
      end else if (stall_cnt > 0) begin
         stall_cnt  <= stall_cnt - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 3) == 0) stall_cnt <= gap_len();
      end
   end

   // monitor: samples accepted responses at the rising edge and checks each field
   always @(posedge clock) begin
      list_rsp_type got;
      list_rsp_type exp_rsp;
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_seen <= rsp_seen + 1;
         got.status = status_type'(rsp_tdata[1:0]);
         got.fpos   = rsp_tdata[9:2];
         got.id     = rsp_tdata[25:10];
         got.name   = rsp_tdata[89:26];
         got.sa     = rsp_tdata[97:90];
         got.sb     = rsp_tdata[105:98];
         got.sc     = rsp_tdata[113:106];
         got.total  = rsp_tdata[123:114];
         got.mean   = rsp_tdata[131:124];
         got.count  = rsp_tdata[139:132];
         got.empty  = rsp_tdata[140];
         if (expected_rsps.size() == 0) begin
            $error("unexpected response transaction");
            fail_count++;
         end else begin
            exp_rsp = expected_rsps.pop_front();
            if (got.status !== exp_rsp.status) begin
               $error("status exp %0d got %0d", exp_rsp.status, got.status); fail_count++;
            end
            if (got.fpos !== exp_rsp.fpos) begin
               $error("found_position exp %0d got %0d", exp_rsp.fpos, got.fpos); fail_count++;
            end
            if (got.id !== exp_rsp.id) begin
               $error("out_id exp %h got %h", exp_rsp.id, got.id); fail_count++;
            end
            if (got.name !== exp_rsp.name) begin
               $error("out_name exp %h got %h", exp_rsp.name, got.name); fail_count++;
            end
            if (got.sa !== exp_rsp.sa) begin
               $error("out_score_a exp %0d got %0d", exp_rsp.sa, got.sa); fail_count++;
            end
            if (got.sb !== exp_rsp.sb) begin
               $error("out_score_b exp %0d got %0d", exp_rsp.sb, got.sb); fail_count++;
            end
            if (got.sc !== exp_rsp.sc) begin
               $error("out_score_c exp %0d got %0d", exp_rsp.sc, got.sc); fail_count++;
            end
            if (got.total !== exp_rsp.total) begin
               $error("total exp %0d got %0d", exp_rsp.total, got.total); fail_count++;
            end
            if (got.mean !== exp_rsp.mean) begin
               $error("mean exp %0d got %0d", exp_rsp.mean, got.mean); fail_count++;
            end
            if (got.count !== exp_rsp.count) begin
               $error("entry_count exp %0d got %0d", exp_rsp.count, got.count); fail_count++;
            end
            if (got.empty !== exp_rsp.empty) begin
               $error("is_empty exp %0d got %0d", exp_rsp.empty, got.empty); fail_count++;
            end
         end
      end
   end

   // watchdog: cycles with no transaction on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   // reset, then wait for drain and report
   initial begin
      int tail;
      repeat (7) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      tail = 0;
      while (tail < 600 && idle_cycles < WATCH_MAX) begin
         @(posedge clock);
         if (stim_done && !req_tvalid && expected_rsps.size() == 0) tail++;
         else tail = 0;
      end
      if (idle_cycles >= WATCH_MAX) begin
         $display("status: fail");
      end else if (fail_count == 0 && !rsp_tvalid) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
